>>> sv/dgs_pkg.sv
// dgs_pkg: shared types, codes and constants of the dependency gate scoreboard
// used by dgs_hash, the scoreboard and the checker; depends on nothing
`timescale 1ns / 1ps

package dgs_pkg;

    // default sizes
    localparam int DGS_DONE_SLOTS = 1024;
    localparam int DGS_GATE_SLOTS = 16;
    localparam int DGS_MAX_DEPS   = 4;

    localparam logic [7:0] RETRY_RESET = 8'd16;

    // handle hash
    localparam logic [63:0] HASH_MUL   = 64'hff51afd7ed558ccd;
    localparam int          HASH_SHIFT = 33;

    // operations
    localparam logic [1:0] OP_EVENT   = 2'd0;
    localparam logic [1:0] OP_DEP     = 2'd1;
    localparam logic [1:0] OP_OUTCOME = 2'd2;

    // event kinds that can be terminal
    localparam logic [2:0] EK_FAILED   = 3'd3;
    localparam logic [2:0] EK_FINISHED = 3'd4;
    localparam logic [2:0] EK_DROPPED  = 3'd5;
    localparam logic [2:0] EK_DEAD     = 3'd6;

    // submit status
    localparam logic [1:0] SS_TRANSIENT = 2'd1;

    // result kinds
    localparam logic [2:0] RK_RELEASE = 3'd0;
    localparam logic [2:0] RK_SUBMIT  = 3'd1;
    localparam logic [2:0] RK_HELD    = 3'd2;
    localparam logic [2:0] RK_FULL    = 3'd3;
    localparam logic [2:0] RK_TOOMANY = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  event_kind;
        logic        cancelled;
        logic [31:0] handle;
        logic        dep_present;
        logic        last_dep;
        logic [15:0] task_tag;
        logic [3:0]  gate_index;
        logic [1:0]  submit_status;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  gate_index_res;
        logic [15:0] task_tag_res;
        logic        last;
    } t_res;

endpackage

>>> sv/dgs_ram.sv
// dgs_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module dgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/dgs_hash.sv
// dgs_hash: multi-cycle home slot hash of a 32-bit handle
// depends on dgs_pkg (hash constants)
`timescale 1ns / 1ps

module dgs_hash import dgs_pkg::*; #(
    parameter int SLOTS = DGS_DONE_SLOTS,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_key,
    output logic          o_done,
    output logic [IW-1:0] o_slot
);

    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    // non power of two: fold the mix into a sum below 2^27, then reduce it by reciprocal
    localparam int            SW      = 27;
    localparam int            SH      = SW + IW;
    localparam logic [28:0]   RECIP   = 29'(((64'd1 << SH) / 64'(SLOTS)) + 64'd1);
    localparam logic [SW-1:0] SLOTS_S = SW'(SLOTS);

    typedef enum logic [2:0] {
        H_IDLE, H_LO, H_HI, H_MIX, H_FOLD, H_RECIP, H_SUB, H_DONE
    } t_hstate;

    t_hstate       r_state;
    logic [31:0]   r_key;
    logic [63:0]   r_prod;
    logic [63:0]   r_x;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_q;
    logic [IW-1:0] r_slot;

    logic [63:0]   w_plo;
    logic [31:0]   w_phi;
    logic [63:0]   w_mix;
    logic [SW-1:0] w_sum;
    logic [55:0]   w_qprod;

    // 64-bit product split into two 32-bit multiplies
    assign w_plo   = 64'(r_key) * 64'(HASH_MUL[31:0]);
    assign w_phi   = r_key * HASH_MUL[63:32];
    assign w_mix   = r_prod ^ (r_prod >> HASH_SHIFT);
    assign w_qprod = 56'(r_sum) * 56'(RECIP);

    // each byte times its weight 2^(8i) mod SLOTS keeps the same remainder
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 8; i++) begin
            w_sum = w_sum + SW'(r_x[8*i +: 8]) * SW'((64'd1 << (8 * i)) % 64'(SLOTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_state <= H_LO;
                    end
                end
                H_LO: begin
                    r_prod  <= w_plo;
                    r_state <= H_HI;
                end
                H_HI: begin
                    r_prod  <= r_prod + {w_phi, 32'd0};
                    r_state <= H_MIX;
                end
                H_MIX: begin
                    if (POW2) begin
                        r_slot  <= w_mix[IW-1:0];
                        r_state <= H_DONE;
                    end else begin
                        r_x     <= w_mix;
                        r_state <= H_FOLD;
                    end
                end
                H_FOLD: begin
                    r_sum   <= w_sum;
                    r_state <= H_RECIP;
                end
                H_RECIP: begin
                    // exact quotient for any sum below 2^27
                    r_q     <= SW'(w_qprod >> SH);
                    r_state <= H_SUB;
                end
                H_SUB: begin
                    r_slot  <= IW'(r_sum - r_q * SLOTS_S);
                    r_state <= H_DONE;
                end
                H_DONE: begin
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == H_DONE);
    assign o_slot = r_slot;

endmodule

>>> sv/dependency_gate_scoreboard.sv
// dependency_gate_scoreboard: fan-in scoreboard, done set memory plus gate table
// depends on dgs_pkg, dgs_ram, dgs_hash
// event: hash of the handle (with a fold and a reciprocal step if DONE_SLOTS is not a
//   power of two), then probes of the done set, then a scan of the gates that compares
//   their stored dependencies, then the finish
// dependency close: one hash and probe chain per nonzero run handle, then, if any is
//   pending, a free-gate scan and a write of each handle; one item at a time, single done-set port
// reset: after reset a clearing pass writes zero to all DONE_SLOTS entries,
//   during which input is stalled
`timescale 1ns / 1ps

module dependency_gate_scoreboard import dgs_pkg::*; #(
    parameter int DONE_SLOTS = DGS_DONE_SLOTS,
    parameter int GATE_SLOTS = DGS_GATE_SLOTS,
    parameter int MAX_DEPS   = DGS_MAX_DEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_item      i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    localparam int IW   = $clog2(DONE_SLOTS);
    localparam int GW   = $clog2(GATE_SLOTS);
    localparam int CW   = $clog2(MAX_DEPS + 1);
    localparam int JW   = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
    localparam int PD   = GATE_SLOTS * MAX_DEPS;
    localparam int AW   = $clog2(PD);
    localparam int HALF = DONE_SLOTS / 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_PRB_RD, S_PRB_CMP,
        S_SC_GATE, S_SC_RD, S_SC_CMP, S_SC_END, S_FIN,
        S_DP_START, S_DP_NEXT, S_DP_DECIDE, S_DP_FREE, S_DP_WR, S_OUTC
    } t_state;

    t_state r_state;

    // done set control
    logic [IW-1:0] r_clr;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_count;
    logic [31:0]   r_key;
    logic          r_ev;     // probe belongs to an event (else to a run close)
    logic          r_hs;     // hash start pulse

    // gate table, flip-flops
    logic          r_live  [GATE_SLOTS];
    logic          r_infl  [GATE_SLOTS];
    logic [CW-1:0] r_rem   [GATE_SLOTS];
    logic [CW-1:0] r_ndeps [GATE_SLOTS];
    logic [15:0]   r_tags  [GATE_SLOTS];
    logic [7:0]    r_att   [GATE_SLOTS];

    // run being built
    logic [31:0]   r_run_h [MAX_DEPS];
    logic [CW-1:0] r_run_cnt;
    logic          r_run_ovf;
    logic [CW-1:0] r_pending;
    logic [15:0]   r_tag;

    // walkers
    logic [GW-1:0] r_g;
    logic [AW-1:0] r_base;
    logic [JW-1:0] r_j;
    logic [1:0]    r_st;

    logic [7:0] r_retry;

    // result held back until we know whether it is the last one
    t_res r_pend;
    logic r_pend_v;
    t_res r_out;
    logic r_ovalid;

    // memory ports
    logic          w_d_we;
    logic [IW-1:0] w_d_waddr;
    logic [31:0]   w_d_wdata;
    logic [31:0]   w_d_rdata;
    logic          w_p_we;
    logic [AW-1:0] w_p_addr;
    logic [31:0]   w_p_rdata;

    logic          w_h_done;
    logic [IW-1:0] w_h_slot;

    logic          w_accept;
    logic          w_can_push;
    logic          w_term;
    logic          w_hit;
    logic          w_empty;
    logic          w_room;
    logic          w_elig;
    logic          w_g_last;
    logic          w_j_run_last;
    logic          w_j_dep_last;
    logic [31:0]   w_run_key;
    logic [7:0]    w_att_inc;
    t_res          w_rel;
    t_res          w_fin;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_can_push = !r_ovalid || !i_out_stall;

    assign w_term = (i_in_data.event_kind == EK_FINISHED) ||
                    (i_in_data.event_kind == EK_DROPPED) ||
                    (i_in_data.event_kind == EK_DEAD) ||
                    ((i_in_data.event_kind == EK_FAILED) && i_in_data.cancelled);

    assign w_hit   = (w_d_rdata == r_key);
    assign w_empty = (w_d_rdata == 32'd0);
    assign w_room  = (r_count < IW'(HALF));

    assign w_elig       = r_live[r_g] && !r_infl[r_g];
    assign w_g_last     = (r_g == GW'(GATE_SLOTS - 1));
    assign w_j_run_last = ((CW'(r_j) + CW'(1)) == r_run_cnt);
    assign w_j_dep_last = ((CW'(r_j) + CW'(1)) == r_ndeps[r_g]);
    assign w_run_key    = r_run_h[r_j];
    assign w_att_inc    = (r_att[r_g] == 8'hff) ? 8'hff : r_att[r_g] + 8'd1;

    always_comb begin
        w_rel.result_kind    = RK_RELEASE;
        w_rel.gate_index_res = 4'(r_g);
        w_rel.task_tag_res   = r_tags[r_g];
        w_rel.last           = 1'b0;
        w_fin                = r_pend;
        w_fin.last           = 1'b1;
    end

    // done set write: clearing pass, or recording a new handle while under half load
    always_comb begin
        w_d_we    = 1'b0;
        w_d_waddr = r_slot;
        w_d_wdata = r_key;
        if (r_state == S_CLEAR) begin
            w_d_we    = 1'b1;
            w_d_waddr = r_clr;
            w_d_wdata = 32'd0;
        end else if (r_state == S_PRB_CMP && r_ev && w_empty && w_room) begin
            w_d_we = 1'b1;
        end
    end

    // dependency handle store, row base plus index
    assign w_p_addr = r_base + AW'(r_j);
    assign w_p_we   = (r_state == S_DP_WR);

    dgs_ram #(.WIDTH(32), .DEPTH(DONE_SLOTS)) u_done_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_d_rdata)
    );

    dgs_ram #(.WIDTH(32), .DEPTH(PD)) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_addr),
        .i_wdata (w_run_key),
        .i_raddr (w_p_addr),
        .o_rdata (w_p_rdata)
    );

    dgs_hash #(.SLOTS(DONE_SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_hs),
        .i_key   (r_key),
        .o_done  (w_h_done),
        .o_slot  (w_h_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_hs      <= 1'b0;
            r_ovalid  <= 1'b0;
            r_pend_v  <= 1'b0;
            r_run_cnt <= '0;
            r_run_ovf <= 1'b0;
            r_retry   <= RETRY_RESET;
            for (int g = 0; g < GATE_SLOTS; g++) begin
                r_live[g] <= 1'b0;
                r_infl[g] <= 1'b0;
                r_rem[g]  <= '0;
                r_att[g]  <= '0;
            end
        end else begin
            r_hs <= 1'b0;
            if (i_cfg_we) begin
                r_retry <= i_cfg_wdata;
            end
            // output beat taken; a push below overrides
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(DONE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_data.operation)
                            OP_EVENT: begin
                                if (w_term && i_in_data.handle != 32'd0) begin
                                    r_key   <= i_in_data.handle;
                                    r_ev    <= 1'b1;
                                    r_hs    <= 1'b1;
                                    r_state <= S_HASH;
                                end
                            end
                            OP_DEP: begin
                                if (i_in_data.dep_present) begin
                                    if (r_run_cnt < CW'(MAX_DEPS)) begin
                                        r_run_h[r_run_cnt[JW-1:0]] <= i_in_data.handle;
                                        r_run_cnt <= r_run_cnt + CW'(1);
                                    end else begin
                                        r_run_ovf <= 1'b1;
                                    end
                                end
                                if (i_in_data.last_dep) begin
                                    r_tag   <= i_in_data.task_tag;
                                    r_state <= S_DP_START;
                                end
                            end
                            OP_OUTCOME: begin
                                // out-of-range gate index is a stray outcome
                                if (32'(i_in_data.gate_index) < GATE_SLOTS) begin
                                    r_g     <= GW'(i_in_data.gate_index);
                                    r_st    <= i_in_data.submit_status;
                                    r_state <= S_OUTC;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_HASH: begin
                    if (w_h_done) begin
                        r_slot  <= w_h_slot;
                        r_state <= S_PRB_RD;
                    end
                end

                S_PRB_RD: begin
                    r_state <= S_PRB_CMP;
                end

                S_PRB_CMP: begin
                    if (w_empty || w_hit) begin
                        if (r_ev) begin
                            if (w_hit) begin
                                // already recorded, nothing changes
                                r_state <= S_IDLE;
                            end else begin
                                // past half load the handle is not stored,
                                // gates still advance on it
                                if (w_room) begin
                                    r_count <= r_count + IW'(1);
                                end
                                r_g      <= '0;
                                r_base   <= '0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_SC_GATE;
                            end
                        end else begin
                            if (!w_hit) begin
                                r_pending <= r_pending + CW'(1);
                            end
                            if (w_j_run_last) begin
                                r_state <= S_DP_DECIDE;
                            end else begin
                                r_j     <= r_j + JW'(1);
                                r_state <= S_DP_NEXT;
                            end
                        end
                    end else begin
                        // linear probe with wrap
                        r_slot  <= (r_slot == IW'(DONE_SLOTS - 1)) ? '0 : r_slot + IW'(1);
                        r_state <= S_PRB_RD;
                    end
                end

                S_SC_GATE: begin
                    if (!w_elig) begin
                        if (w_g_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_g    <= r_g + GW'(1);
                            r_base <= r_base + AW'(MAX_DEPS);
                        end
                    end else if (r_ndeps[r_g] == '0) begin
                        r_state <= S_SC_END;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_SC_RD;
                    end
                end

                S_SC_RD: begin
                    r_state <= S_SC_CMP;
                end

                S_SC_CMP: begin
                    if (w_p_rdata == r_key && r_rem[r_g] != '0) begin
                        r_rem[r_g] <= r_rem[r_g] - CW'(1);
                        r_state    <= S_SC_END;
                    end else if (w_j_dep_last) begin
                        r_state <= S_SC_END;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_SC_RD;
                    end
                end

                S_SC_END: begin
                    if (r_rem[r_g] != '0 || !r_pend_v || w_can_push) begin
                        if (r_rem[r_g] == '0) begin
                            // release; the previous release is now known not last
                            if (r_pend_v) begin
                                r_ovalid <= 1'b1;
                                r_out    <= r_pend;
                            end
                            r_pend       <= w_rel;
                            r_pend_v     <= 1'b1;
                            r_infl[r_g]  <= 1'b1;
                        end
                        if (w_g_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_g     <= r_g + GW'(1);
                            r_base  <= r_base + AW'(MAX_DEPS);
                            r_state <= S_SC_GATE;
                        end
                    end
                end

                S_FIN: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_can_push) begin
                        r_ovalid <= 1'b1;
                        r_out    <= w_fin;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end

                S_DP_START: begin
                    r_j       <= '0;
                    r_pending <= '0;
                    if (r_run_ovf) begin
                        r_pend    <= '{RK_TOOMANY, 4'd0, r_tag, 1'b0};
                        r_pend_v  <= 1'b1;
                        r_run_cnt <= '0;
                        r_run_ovf <= 1'b0;
                        r_state   <= S_FIN;
                    end else if (r_run_cnt == '0) begin
                        r_state <= S_DP_DECIDE;
                    end else begin
                        r_state <= S_DP_NEXT;
                    end
                end

                S_DP_NEXT: begin
                    if (w_run_key == 32'd0) begin
                        // handle zero is never done
                        r_pending <= r_pending + CW'(1);
                        if (w_j_run_last) begin
                            r_state <= S_DP_DECIDE;
                        end else begin
                            r_j <= r_j + JW'(1);
                        end
                    end else begin
                        r_key   <= w_run_key;
                        r_ev    <= 1'b0;
                        r_hs    <= 1'b1;
                        r_state <= S_HASH;
                    end
                end

                S_DP_DECIDE: begin
                    if (r_pending == '0) begin
                        r_pend    <= '{RK_SUBMIT, 4'd0, r_tag, 1'b0};
                        r_pend_v  <= 1'b1;
                        r_run_cnt <= '0;
                        r_run_ovf <= 1'b0;
                        r_state   <= S_FIN;
                    end else begin
                        r_g     <= '0;
                        r_base  <= '0;
                        r_state <= S_DP_FREE;
                    end
                end

                S_DP_FREE: begin
                    if (!r_live[r_g]) begin
                        r_j     <= '0;
                        r_state <= S_DP_WR;
                    end else if (w_g_last) begin
                        r_pend    <= '{RK_FULL, 4'd0, r_tag, 1'b0};
                        r_pend_v  <= 1'b1;
                        r_run_cnt <= '0;
                        r_run_ovf <= 1'b0;
                        r_state   <= S_FIN;
                    end else begin
                        r_g    <= r_g + GW'(1);
                        r_base <= r_base + AW'(MAX_DEPS);
                    end
                end

                S_DP_WR: begin
                    // one handle into the gate's row each cycle
                    if (w_j_run_last) begin
                        r_live[r_g]  <= 1'b1;
                        r_infl[r_g]  <= 1'b0;
                        r_rem[r_g]   <= r_pending;
                        r_ndeps[r_g] <= r_run_cnt;
                        r_tags[r_g]  <= r_tag;
                        r_att[r_g]   <= '0;
                        r_pend       <= '{RK_HELD, 4'(r_g), r_tag, 1'b0};
                        r_pend_v     <= 1'b1;
                        r_run_cnt    <= '0;
                        r_run_ovf    <= 1'b0;
                        r_state      <= S_FIN;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end

                S_OUTC: begin
                    if (r_live[r_g] && r_infl[r_g]) begin
                        r_infl[r_g] <= 1'b0;
                        if (r_st == SS_TRANSIENT) begin
                            r_att[r_g] <= w_att_inc;
                            if (w_att_inc >= r_retry) begin
                                r_live[r_g] <= 1'b0;
                            end
                        end else begin
                            r_live[r_g] <= 1'b0;
                        end
                    end
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

>>> sv/dgs_checker.sv
// dgs_checker: port-level assertions for the dependency gate scoreboard
// depends on dgs_pkg; bound to dependency_gate_scoreboard below
`timescale 1ns / 1ps

module dgs_checker import dgs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_res i_out_data
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("output beat changed while stalled");

    // clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> i_in_stall)
        else $error("input open during clearing pass");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.result_kind <= RK_TOOMANY)
        else $error("result kind out of range");

    // single-result kinds carry gate zero and close the item
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.result_kind == RK_SUBMIT ||
            i_out_data.result_kind == RK_FULL || i_out_data.result_kind == RK_TOOMANY)
        |-> i_out_data.gate_index_res == 4'd0 && i_out_data.last)
        else $error("bad single result");

    a_held_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == RK_HELD |-> i_out_data.last)
        else $error("gate held result not last");

endmodule

bind dependency_gate_scoreboard dgs_checker u_dgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
